### rtl/core/grce_pkg.sv
// ----------------------------------------------------------------------------
// grce_pkg
// Shared types, constants and small decode functions of the report change
// event generator.
// ----------------------------------------------------------------------------
package grce_pkg;

  // Report framing
  localparam int REPORT_BYTES     = 64;
  localparam int MAX_REPORT_BYTES = 256;
  localparam int CNT_W            = $clog2(MAX_REPORT_BYTES + 1);

  // Byte positions inside the report
  localparam int HEADER_LEN      = 3;
  localparam int POS_BTN_FACE    = 8;
  localparam int POS_BTN_MISC    = 9;
  localparam int POS_BTN_THUMBL  = 10;
  localparam int POS_BTN_THUMBR  = 11;
  localparam int POS_AXIS_FIRST  = 44;
  localparam int POS_AXIS_LAST   = 55;

  localparam int NUM_KEYS    = 11;
  localparam int NUM_BUTTONS = 15;
  localparam int NUM_AXES    = 6;

  // Direction bits inside the button word
  localparam int BTN_UP    = 11;
  localparam int BTN_DOWN  = 12;
  localparam int BTN_LEFT  = 13;
  localparam int BTN_RIGHT = 14;

  // Axis indexes
  localparam logic [2:0] AXIS_LX    = 3'd0;
  localparam logic [2:0] AXIS_LY    = 3'd1;
  localparam logic [2:0] AXIS_LTRIG = 3'd2;
  localparam logic [2:0] AXIS_RX    = 3'd3;
  localparam logic [2:0] AXIS_RY    = 3'd4;
  localparam logic [2:0] AXIS_RTRIG = 3'd5;

  // Event codes of the hats
  localparam logic [3:0] CODE_HAT_X = 4'd6;
  localparam logic [3:0] CODE_HAT_Y = 4'd7;

  // Change candidates: keys, then axes, then hat Y, then hat X
  localparam int CAND_AXIS0 = NUM_KEYS;
  localparam int CAND_HAT_Y = NUM_KEYS + NUM_AXES;
  localparam int CAND_HAT_X = CAND_HAT_Y + 1;
  localparam int NUM_CAND   = CAND_HAT_X + 1;
  localparam int CAND_W     = $clog2(NUM_CAND);

  localparam logic [15:0] AXIS_MOST_NEG = 16'h8000;
  localparam logic [15:0] AXIS_CROPPED  = 16'h8001;

  // Snapshot queue
  localparam int SNAP_DEPTH = 2;
  localparam int SNAP_PTR_W = $clog2(SNAP_DEPTH);

  // Configuration register indexes
  localparam logic [1:0] REG_DROP_REPORTS = 2'd0;

  typedef enum logic [1:0] {
    KIND_KEY = 2'd0,
    KIND_ABS = 2'd1,
    KIND_SYN = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0]       buttons;
    logic [NUM_AXES-1:0][15:0]    axes;
  } snapshot_t;

  function automatic logic [7:0] header_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'h01;
      2'd1:    val = 8'h00;
      2'd2:    val = 8'h09;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Axis fed by each byte pair from the first axis byte on
  function automatic logic [2:0] pair_axis(input logic [2:0] pair);
    logic [2:0] axis;
    unique case (pair)
      3'd0:    axis = AXIS_LTRIG;
      3'd1:    axis = AXIS_RTRIG;
      3'd2:    axis = AXIS_LX;
      3'd3:    axis = AXIS_LY;
      3'd4:    axis = AXIS_RX;
      3'd5:    axis = AXIS_RY;
      default: axis = AXIS_LX;
    endcase
    return axis;
  endfunction

  function automatic logic axis_is_signed(input logic [2:0] axis);
    return (axis == AXIS_LX) || (axis == AXIS_LY) || (axis == AXIS_RX) || (axis == AXIS_RY);
  endfunction

  function automatic logic axis_is_negated(input logic [2:0] axis);
    return (axis == AXIS_LY) || (axis == AXIS_RY);
  endfunction

  function automatic logic [15:0] crop_axis(input logic [15:0] raw, input logic [2:0] axis);
    return (axis_is_signed(axis) && raw == AXIS_MOST_NEG) ? AXIS_CROPPED : raw;
  endfunction

endpackage

### rtl/core/gamepad_report_change_events.sv
// ----------------------------------------------------------------------------
// gamepad_report_change_events
// Controller input report to key/axis/hat change events, one byte per cycle while not full.
// ----------------------------------------------------------------------------
// Report bytes enter through the push/full side at one byte per cycle while
// full is low. When the last byte of a 64-byte report with header 01 00 09
// arrives and drop mode is off, the front end hands a snapshot of the 15
// button bits and 6 axes to a two-entry snapshot queue; full is high only
// while that queue holds two snapshots. The back end loads a snapshot, then
// gives each change as the event, then its sync, while the result register
// is free. Results leave through empty/pop; the last sync of a report carries
// last_of_run. A report with no change produces nothing. Signed axes have
// -32768 cropped to -32767 and the Y axes come out negated; hats read -1, 0
// or +1. The configuration port holds one register, drop_reports at byte
// address 0, which must only be written while idle.
// ----------------------------------------------------------------------------
module gamepad_report_change_events (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // report bytes
  input  logic               push,
  output logic               full,
  input  logic [7:0]         report_byte,
  input  logic               end_of_report,
  // events
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         event_kind,
  output logic [3:0]         event_code,
  output logic signed [16:0] event_value,
  output logic               last_of_run
);
  import grce_pkg::*;

  logic      drop_reports;
  logic      snap_push;
  logic      snap_full;
  logic      snap_valid;
  logic      snap_pop;
  snapshot_t snap_in;
  snapshot_t snap_out;

  // Register file: a transfer completes on the access cycle, no wait states
  assign pready = 1'b1;
  assign prdata = (paddr == REG_DROP_REPORTS) ? {31'b0, drop_reports} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_reports <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_DROP_REPORTS) begin
      drop_reports <= pwdata[0];
    end
  end

  // Front: framing, header check and unpacking
  grce_front u_front (
    .clk           (clk),
    .rst           (rst),
    .drop_reports  (drop_reports),
    .push          (push),
    .full          (full),
    .report_byte   (report_byte),
    .end_of_report (end_of_report),
    .snap_full     (snap_full),
    .snap_push     (snap_push),
    .snap_data     (snap_in)
  );

  // Hold accepted snapshots until the back end takes them
  grce_snap_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (snap_push),
    .wr_data (snap_in),
    .q_full  (snap_full),
    .rd_en   (snap_pop),
    .q_valid (snap_valid),
    .rd_data (snap_out)
  );

  // Back: compare with the last accepted report and walk the changes
  grce_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (snap_valid),
    .q_data      (snap_out),
    .q_pop       (snap_pop),
    .empty       (empty),
    .pop         (pop),
    .event_kind  (event_kind),
    .event_code  (event_code),
    .event_value (event_value),
    .last_of_run (last_of_run)
  );

endmodule

### rtl/core/grce_front.sv
// ----------------------------------------------------------------------------
// grce_front
// Takes report bytes, tracks length and header, unpacks buttons and axes,
// and hands a snapshot to the queue at the end of each accepted report.
// ----------------------------------------------------------------------------
module grce_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                drop_reports,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          report_byte,
  input  logic                end_of_report,
  input  logic                snap_full,
  output logic                snap_push,
  output grce_pkg::snapshot_t snap_data
);
  import grce_pkg::*;

  logic [CNT_W-1:0]       byte_count;
  logic                   header_ok;
  logic [NUM_BUTTONS-1:0] current_buttons;
  logic [NUM_AXES-1:0][15:0] current_axes;

  logic                   header_ok_next;
  logic [NUM_BUTTONS-1:0] current_buttons_next;
  logic [NUM_AXES-1:0][15:0] current_axes_next;

  logic                   in_range;
  logic                   take;
  logic [CNT_W-1:0]       axis_off;
  logic [2:0]             axis_sel;
  logic                   report_ok;

  assign full     = snap_full;
  assign take     = push && !full;
  assign in_range = byte_count < CNT_W'(MAX_REPORT_BYTES);
  assign axis_off = byte_count - CNT_W'(POS_AXIS_FIRST);
  assign axis_sel = pair_axis(axis_off[3:1]);

  always_comb begin
    header_ok_next = header_ok;
    if (in_range && byte_count < CNT_W'(HEADER_LEN) &&
        report_byte != header_byte(byte_count[1:0])) begin
      header_ok_next = 1'b0;
    end
  end

  always_comb begin
    current_buttons_next = current_buttons;
    if (in_range) begin
      if (byte_count == CNT_W'(POS_BTN_FACE)) begin
        current_buttons_next[0] = report_byte[7];
        current_buttons_next[1] = report_byte[5];
        current_buttons_next[2] = report_byte[6];
        current_buttons_next[3] = report_byte[4];
        current_buttons_next[4] = report_byte[3];
        current_buttons_next[5] = report_byte[2];
      end
      if (byte_count == CNT_W'(POS_BTN_MISC)) begin
        current_buttons_next[6]         = report_byte[4];
        current_buttons_next[7]         = report_byte[6];
        current_buttons_next[8]         = report_byte[5];
        current_buttons_next[BTN_UP]    = report_byte[0];
        current_buttons_next[BTN_DOWN]  = report_byte[3];
        current_buttons_next[BTN_LEFT]  = report_byte[2];
        current_buttons_next[BTN_RIGHT] = report_byte[1];
      end
      if (byte_count == CNT_W'(POS_BTN_THUMBL)) begin
        current_buttons_next[9] = report_byte[6];
      end
      if (byte_count == CNT_W'(POS_BTN_THUMBR)) begin
        current_buttons_next[10] = report_byte[2];
      end
    end
  end

  always_comb begin
    current_axes_next = current_axes;
    if (byte_count >= CNT_W'(POS_AXIS_FIRST) && byte_count <= CNT_W'(POS_AXIS_LAST)) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (axis_sel == 3'(i)) begin
          if (byte_count[0]) begin
            current_axes_next[i][15:8] = report_byte;
          end else begin
            current_axes_next[i][7:0] = report_byte;
          end
        end
      end
    end
  end

  // Length is exactly REPORT_BYTES only when this byte sits at REPORT_BYTES-1
  assign report_ok = end_of_report && !drop_reports && header_ok_next &&
                     (byte_count == CNT_W'(REPORT_BYTES - 1));

  assign snap_push         = take && report_ok;
  assign snap_data.buttons = current_buttons_next;
  assign snap_data.axes    = current_axes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      header_ok       <= 1'b1;
      current_buttons <= '0;
      current_axes    <= '0;
    end else if (take) begin
      current_buttons <= current_buttons_next;
      current_axes    <= current_axes_next;
      if (end_of_report) begin
        byte_count <= '0;
        header_ok  <= 1'b1;
      end else begin
        header_ok <= header_ok_next;
        if (in_range) begin
          byte_count <= byte_count + CNT_W'(1);
        end
      end
    end
  end

endmodule

### rtl/core/grce_snap_queue.sv
// ----------------------------------------------------------------------------
// grce_snap_queue
// Short queue of accepted report snapshots between front and back.
// ----------------------------------------------------------------------------
module grce_snap_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  grce_pkg::snapshot_t wr_data,
  output logic                q_full,
  input  logic                rd_en,
  output logic                q_valid,
  output grce_pkg::snapshot_t rd_data
);
  import grce_pkg::*;

  snapshot_t               entries [SNAP_DEPTH];
  logic [SNAP_PTR_W-1:0]   wr_ptr;
  logic [SNAP_PTR_W-1:0]   rd_ptr;
  logic [SNAP_PTR_W:0]     count;

  assign q_full  = count == (SNAP_PTR_W+1)'(SNAP_DEPTH);
  assign q_valid = count != '0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + SNAP_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + SNAP_PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + (SNAP_PTR_W+1)'(1);
        2'b01:   count <= count - (SNAP_PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/grce_back.sv
// ----------------------------------------------------------------------------
// grce_back
// Compares each snapshot with the last accepted one and walks the changes,
// giving one event and one sync per change into the result register.
// ----------------------------------------------------------------------------
module grce_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  grce_pkg::snapshot_t q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          event_kind,
  output logic [3:0]          event_code,
  output logic signed [16:0]  event_value,
  output logic                last_of_run
);
  import grce_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVENT = 3'b010,
    ST_SYNC  = 3'b100
  } back_state_t;

  back_state_t               state;
  logic [NUM_BUTTONS-1:0]    previous_buttons;
  logic [NUM_AXES-1:0][15:0] previous_axes;
  logic [NUM_CAND-1:0]       mask;
  logic                      out_valid;

  logic [NUM_AXES-1:0][15:0] cropped;
  logic [NUM_BUTTONS-1:0]    diff;
  logic [NUM_CAND-1:0]       load_mask;
  logic [NUM_CAND-1:0]       mask_rest;
  logic [CAND_W-1:0]         cand;
  logic [2:0]                axis_idx;
  logic [15:0]               axis_raw;
  logic signed [16:0]        axis_val;
  event_kind_t               ev_kind;
  logic [3:0]                ev_code;
  logic signed [16:0]        ev_value;
  logic                      out_free;

  function automatic logic [CAND_W-1:0] lowest_set(input logic [NUM_CAND-1:0] m);
    logic [CAND_W-1:0] idx;
    idx = '0;
    for (int i = NUM_CAND - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = CAND_W'(i);
      end
    end
    return idx;
  endfunction

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  // Change mask of the queue head against the last accepted report
  always_comb begin
    diff = q_data.buttons ^ previous_buttons;
    for (int i = 0; i < NUM_AXES; i++) begin
      cropped[i] = crop_axis(q_data.axes[i], 3'(i));
      load_mask[CAND_AXIS0 + i] = cropped[i] != previous_axes[i];
    end
    load_mask[NUM_KEYS-1:0] = diff[NUM_KEYS-1:0];
    load_mask[CAND_HAT_Y]   = diff[BTN_UP] || diff[BTN_DOWN];
    load_mask[CAND_HAT_X]   = diff[BTN_LEFT] || diff[BTN_RIGHT];
  end

  assign cand      = lowest_set(mask);
  assign mask_rest = mask & (mask - NUM_CAND'(1));
  assign axis_idx  = 3'(cand - CAND_W'(CAND_AXIS0));
  assign axis_raw  = previous_axes[axis_idx];

  always_comb begin
    axis_val = axis_is_signed(axis_idx) ? {axis_raw[15], axis_raw} : {1'b0, axis_raw};
    if (axis_is_negated(axis_idx)) begin
      axis_val = -axis_val;
    end
  end

  // Event of the lowest pending candidate; previous_* now holds that report
  always_comb begin
    if (cand < CAND_W'(NUM_KEYS)) begin
      ev_kind  = KIND_KEY;
      ev_code  = cand[3:0];
      ev_value = {16'b0, previous_buttons[cand[3:0]]};
    end else if (cand < CAND_W'(CAND_HAT_Y)) begin
      ev_kind  = KIND_ABS;
      ev_code  = {1'b0, axis_idx};
      ev_value = axis_val;
    end else if (cand == CAND_W'(CAND_HAT_Y)) begin
      ev_kind  = KIND_ABS;
      ev_code  = CODE_HAT_Y;
      ev_value = 17'(signed'({1'b0, previous_buttons[BTN_DOWN]})) -
                 17'(signed'({1'b0, previous_buttons[BTN_UP]}));
    end else begin
      ev_kind  = KIND_ABS;
      ev_code  = CODE_HAT_X;
      ev_value = 17'(signed'({1'b0, previous_buttons[BTN_RIGHT]})) -
                 17'(signed'({1'b0, previous_buttons[BTN_LEFT]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      previous_buttons <= '0;
      previous_axes    <= '0;
      mask             <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            previous_buttons <= q_data.buttons;
            previous_axes    <= cropped;
            mask             <= load_mask;
            if (load_mask != '0) begin
              state <= ST_EVENT;
            end
          end
        end
        ST_EVENT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            event_kind  <= ev_kind;
            event_code  <= ev_code;
            event_value <= ev_value;
            last_of_run <= 1'b0;
            state       <= ST_SYNC;
          end
        end
        ST_SYNC: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            event_kind  <= KIND_SYN;
            event_code  <= '0;
            event_value <= '0;
            last_of_run <= mask_rest == '0;
            mask        <= mask_rest;
            state       <= (mask_rest == '0) ? ST_IDLE : ST_EVENT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_last_is_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> event_kind == KIND_SYN)
    else $error("last_of_run set on a non-sync event");

  a_pending_change: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVENT || state == ST_SYNC |-> mask != '0)
    else $error("event walk running with no pending change");

  a_event_then_sync: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVENT && out_free |=> out_valid && event_kind != KIND_SYN && state == ST_SYNC)
    else $error("event not followed by its sync slot");

  a_load_starts_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && q_valid && load_mask != '0 |=> state == ST_EVENT)
    else $error("changed snapshot did not start the event walk");

endmodule
